>>> design/bpl_pkg.sv
// ----------------------------------------------------------------------------
// Bit-plane LED pixel buffer package
// Shared sizes, function codes, sequencer states and the helpers that map a
// packed colour to and from the stored green, red, blue bit stream.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int LANES         = 8;
    localparam int LEDS_PER_LANE = 64;
    localparam int COLOR_BYTES   = 3;

    localparam int BPP         = 8 * COLOR_BYTES;
    localparam int BPP_W       = $clog2(BPP);
    localparam int STORE_DEPTH = LEDS_PER_LANE * BPP;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CH_W        = $clog2(COLOR_BYTES);

    localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

    // Dimming: x / 100 is done as (x * 5243) >> 19, exact for x up to 25500.
    localparam int          PCT_MAX      = 100;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [2:0] FUNC_SET   = 3'd0;
    localparam logic [2:0] FUNC_GET   = 3'd1;
    localparam logic [2:0] FUNC_OR    = 3'd2;
    localparam logic [2:0] FUNC_XOR   = 3'd3;
    localparam logic [2:0] FUNC_DIM   = 3'd4;
    localparam logic [2:0] FUNC_FILL  = 3'd5;
    localparam logic [2:0] FUNC_PLANE = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RLAST,
        S_CALC,
        S_DIM,
        S_WRITE,
        S_FILL,
        S_PBYTE
    } state_t;

    typedef logic [BPP-1:0] stream_t;

    // Bit offset in the packed colour of the channel at stored order k.
    function automatic int chan_shift(input int k);
        int sh;
        if (k == 0)
            sh = 8 * (COLOR_BYTES - 2);
        else if (k == 1)
            sh = 8 * (COLOR_BYTES - 1);
        else
            sh = 8 * (COLOR_BYTES - 1 - k);
        return sh;
    endfunction

    function automatic stream_t color_to_stream(input logic [31:0] col);
        stream_t s;
        s = '0;
        for (int k = 0; k < COLOR_BYTES; k++)
        begin
            s[BPP-1-8*k -: 8] = col[chan_shift(k) +: 8];
        end
        return s;
    endfunction

    function automatic logic [31:0] stream_to_color(input stream_t s);
        logic [31:0] col;
        col = '0;
        for (int k = 0; k < COLOR_BYTES; k++)
        begin
            col[chan_shift(k) +: 8] = s[BPP-1-8*k -: 8];
        end
        return col;
    endfunction

endpackage

>>> design/bit_plane_led_pixel_buffer_top.sv
// ----------------------------------------------------------------------------
// Bit-plane LED pixel buffer
// Multi-lane, bit-transposed frame store with pixel set, get, OR, XOR, dim,
// fill and raw plane byte read, driven by a small sequencer.
// ----------------------------------------------------------------------------
// An out of range request raises done with status set, an unused one done
// alone. A plane byte read reads a single byte, get reads the pixel's BPP
// bytes, and set, OR, XOR and dim read them and write them back, dim running
// the dimming unit in between. A fill writes every byte once. The plane store
// is byte wide: one byte is read or written per cycle while a pixel is read or
// written, a fill runs or the store is cleared. The receiver cannot stall, so
// a new request may be accepted in the cycle that carries the done strobe.
// After reset the store is cleared one byte a cycle while busy is high.
// ----------------------------------------------------------------------------
module bit_plane_led_pixel_buffer_top
    import bpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [3:0]  lane,
    input  logic [7:0]  pos,
    input  logic [31:0] color,
    input  logic [7:0]  percent,
    input  logic [10:0] plane_index,
    output logic        done,
    output logic        status,
    output logic [31:0] pixel_color,
    output logic [7:0]  plane_byte
);

    // Sequencer state and counters.
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic [BPP_W-1:0]  pix_cnt_reg, pix_cnt_next;
    logic              rvalid_reg, rvalid_next;
    logic              done_reg,  done_next;

    // Request and working data.
    logic [ADDR_W-1:0] base_reg,   base_next;
    logic [2:0]        lane_reg,   lane_next;
    logic [2:0]        func_reg,   func_next;
    logic [31:0]       color_reg,  color_next;
    logic [7:0]        pct_reg,    pct_next;
    stream_t           stream_reg, stream_next;
    logic [7:0]        buf_reg [BPP];
    logic              status_reg, status_next;
    logic [31:0]       pcol_reg,   pcol_next;
    logic [7:0]        pbyte_reg,  pbyte_next;

    // Plane store port.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // Handshake between the sequencer and the dimming unit.
    logic    dim_start;
    logic    dim_done;
    stream_t dim_stream;

    logic       accept;
    logic       pixel_ok;
    logic       plane_ok;
    logic [7:0] lane_bit;

    assign accept   = start && (state_reg == S_IDLE);
    assign pixel_ok = (32'(lane) < LANES) && (32'(pos) < LEDS_PER_LANE);
    assign plane_ok = 32'(plane_index) < STORE_DEPTH;
    assign lane_bit = 8'd1 << lane_reg;

    bpl_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpl_dim u_dim (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dim_start),
        .stream_in  (stream_reg),
        .percent    (pct_reg),
        .done       (dim_done),
        .stream_out (dim_stream)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func) inside
                        FUNC_SET, FUNC_GET, FUNC_OR, FUNC_XOR, FUNC_DIM:
                        begin
                            if (pixel_ok)
                            begin
                                state_next = S_READ;
                            end
                        end
                        FUNC_FILL:  state_next = S_FILL;
                        FUNC_PLANE:
                        begin
                            if (plane_ok)
                            begin
                                state_next = S_PBYTE;
                            end
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (pix_cnt_reg == BPP_W'(BPP - 1))
                begin
                    state_next = S_RLAST;
                end
            end
            S_RLAST:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                unique case (func_reg)
                    FUNC_GET: state_next = S_IDLE;
                    FUNC_DIM: state_next = S_DIM;
                    default:  state_next = S_WRITE;
                endcase
            end
            S_DIM:
            begin
                if (dim_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (pix_cnt_reg == BPP_W'(BPP - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_PBYTE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and store port control.
    always_comb
    begin
        addr_next      = addr_reg;
        pix_cnt_next   = pix_cnt_reg;
        rvalid_next    = 1'b0;
        done_next      = 1'b0;
        base_next      = base_reg;
        lane_next      = lane_reg;
        func_next      = func_reg;
        color_next     = color_reg;
        pct_next       = pct_reg;
        stream_next    = stream_reg;
        status_next    = status_reg;
        pcol_next      = pcol_reg;
        pbyte_next     = pbyte_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = 8'h00;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;
        dim_start      = 1'b0;

        // Each byte read arrives in the cycle after its address.
        if (rvalid_reg)
        begin
            stream_next = {stream_reg[BPP-2:0], mem_rdata[lane_reg]};
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = 1'b0;
                    pcol_next   = '0;
                    pbyte_next  = '0;
                    func_next   = func;
                    lane_next   = lane[2:0];
                    color_next  = color;
                    pct_next    = percent;
                    base_next   = ADDR_W'(32'(pos) * BPP);
                    addr_next   = ADDR_W'(32'(pos) * BPP);
                    pix_cnt_next = '0;
                    unique case (func) inside
                        FUNC_SET, FUNC_GET, FUNC_OR, FUNC_XOR, FUNC_DIM:
                        begin
                            if (!pixel_ok)
                            begin
                                status_next = 1'b1;
                                done_next   = 1'b1;
                            end
                        end
                        FUNC_FILL:
                        begin
                            addr_next   = '0;
                            stream_next = color_to_stream(color);
                            pcol_next   = stream_to_color(color_to_stream(color));
                        end
                        FUNC_PLANE:
                        begin
                            if (plane_ok)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(plane_index);
                            end
                            else
                            begin
                                status_next = 1'b1;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_re       = 1'b1;
                rvalid_next  = 1'b1;
                addr_next    = addr_reg + 1'b1;
                pix_cnt_next = pix_cnt_reg + 1'b1;
                if (pix_cnt_reg == BPP_W'(BPP - 1))
                begin
                    addr_next    = base_reg;
                    pix_cnt_next = '0;
                end
            end
            S_RLAST:
            begin
            end
            S_CALC:
            begin
                unique case (func_reg)
                    FUNC_SET:
                    begin
                        stream_next = color_to_stream(color_reg);
                        pcol_next   = stream_to_color(color_to_stream(color_reg));
                    end
                    FUNC_OR:
                    begin
                        stream_next = color_to_stream(color_reg) | stream_reg;
                        pcol_next   = stream_to_color(color_to_stream(color_reg) | stream_reg);
                    end
                    FUNC_XOR:
                    begin
                        stream_next = color_to_stream(color_reg) ^ stream_reg;
                        pcol_next   = stream_to_color(color_to_stream(color_reg) ^ stream_reg);
                    end
                    FUNC_DIM:
                    begin
                        dim_start = 1'b1;
                    end
                    default:
                    begin
                        pcol_next = stream_to_color(stream_reg);
                        done_next = 1'b1;
                    end
                endcase
            end
            S_DIM:
            begin
                if (dim_done)
                begin
                    stream_next = dim_stream;
                    pcol_next   = stream_to_color(dim_stream);
                end
            end
            S_WRITE:
            begin
                // Replace this lane's bit in the byte read earlier.
                mem_we       = 1'b1;
                mem_wdata    = (buf_reg[0] & ~lane_bit) |
                               (stream_reg[BPP-1] ? lane_bit : 8'h00);
                stream_next  = {stream_reg[BPP-2:0], stream_reg[BPP-1]};
                addr_next    = addr_reg + 1'b1;
                pix_cnt_next = pix_cnt_reg + 1'b1;
                if (pix_cnt_reg == BPP_W'(BPP - 1))
                begin
                    done_next = 1'b1;
                end
            end
            S_FILL:
            begin
                // The stream rotates once per pixel, so its top bit follows
                // the byte position within each pixel.
                mem_we      = 1'b1;
                mem_wdata   = stream_reg[BPP-1] ? LANE_MASK : 8'h00;
                stream_next = {stream_reg[BPP-2:0], stream_reg[BPP-1]};
                addr_next   = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    done_next = 1'b1;
                end
            end
            S_PBYTE:
            begin
                pbyte_next = mem_rdata;
                done_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            pix_cnt_reg <= '0;
            rvalid_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            pix_cnt_reg <= pix_cnt_next;
            rvalid_reg  <= rvalid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        lane_reg   <= lane_next;
        func_reg   <= func_next;
        color_reg  <= color_next;
        pct_reg    <= pct_next;
        stream_reg <= stream_next;
        status_reg <= status_next;
        pcol_reg   <= pcol_next;
        pbyte_reg  <= pbyte_next;
    end

    // Byte line: the pixel's bytes enter at the top while they are read and
    // leave at the bottom, in address order, while they are written back.
    always_ff @(posedge clk)
    begin
        if (rvalid_reg || (state_reg == S_WRITE))
        begin
            for (int i = 0; i < BPP - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[BPP-1] <= rvalid_reg ? mem_rdata : buf_reg[0];
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign pixel_color = pcol_reg;
    assign plane_byte  = pbyte_reg;

    // The store is only written while clearing, filling or writing a pixel back.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WRITE || state_reg == S_FILL || state_reg == S_CLEAR))
        else $error("plane store written outside a write phase");

    // The dimming unit only finishes while the sequencer waits for it.
    a_dim_done: assert property (@(posedge clk) disable iff (!rst_n)
        dim_done |-> (state_reg == S_DIM))
        else $error("dimming result arrived outside the dim wait");

    // The last byte of a pixel read must land in the cycle after the read phase.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RLAST) |-> rvalid_reg)
        else $error("final pixel byte not captured");

endmodule

>>> design/bpl_mem.sv
// ----------------------------------------------------------------------------
// Plane store
// Byte-wide store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpl_mem
    import bpl_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bpl_dim.sv
// ----------------------------------------------------------------------------
// Dimming unit
// Scales each channel of a pixel stream by (100 - percent) / 100, or by zero
// for a percent above 100, with one shared multiplier, channel by channel.
// ----------------------------------------------------------------------------
module bpl_dim
    import bpl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  stream_t   stream_in,
    input  logic [7:0] percent,
    output logic      done,
    output stream_t   stream_out
);

    logic            run_reg,   run_next;
    logic            phase_reg, phase_next;
    logic [CH_W-1:0] k_reg,     k_next;
    logic            done_reg,  done_next;
    logic [6:0]      m_reg,     m_next;
    stream_t         st_reg,    st_next;
    logic [14:0]     prod_reg,  prod_next;

    logic [14:0] mul_a;
    logic [12:0] mul_b;
    logic [27:0] mul_p;

    // The single multiplier: channel times factor, then product times 1/100.
    assign mul_a = phase_reg ? prod_reg : {7'd0, st_reg[BPP-1 -: 8]};
    assign mul_b = phase_reg ? DIV100_MUL : {6'd0, m_reg};
    assign mul_p = 28'(mul_a) * 28'(mul_b);

    always_comb
    begin
        run_next   = run_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        m_next     = m_reg;
        st_next    = st_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            run_next   = 1'b1;
            phase_next = 1'b0;
            k_next     = '0;
            st_next    = stream_in;
            m_next     = (percent > 8'(PCT_MAX)) ? 7'd0 : 7'(PCT_MAX - int'(percent));
        end
        else if (run_reg)
        begin
            if (!phase_reg)
            begin
                prod_next  = mul_p[14:0];
                phase_next = 1'b1;
            end
            else
            begin
                st_next    = {st_reg[BPP-9:0], mul_p[DIV100_SHIFT+7:DIV100_SHIFT]};
                phase_next = 1'b0;
                k_next     = k_reg + 1'b1;
                if (k_reg == CH_W'(COLOR_BYTES - 1))
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        st_reg   <= st_next;
        prod_reg <= prod_next;
    end

    assign done       = done_reg;
    assign stream_out = st_reg;

endmodule
